>>> design/tile_average_pixelation_defines.svh
// Assertion macros used by the top-level design file.
`ifndef TILE_AVERAGE_PIXELATION_DEFINES_SVH
`define TILE_AVERAGE_PIXELATION_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define TAP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, checked on every rising edge outside reset.
`define TAP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

>>> design/tap_pkg.sv
package tap_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_TILE   = 64;
  localparam int MAX_HEIGHT = 4096;

  localparam int PIX_W   = 8;
  localparam int SUM_W   = 20;
  localparam int AREA_W  = 13;
  localparam int TCOL_W  = 10;
  localparam int TROW_W  = 11;
  localparam int TSIZE_W = 7;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam int CIT_W   = 6;
  localparam int WREG_W  = 12;
  localparam int HREG_W  = 13;
  localparam int CFG_W   = 13;
  localparam int CIDX_W  = 2;

  localparam int SLOTS   = 1024;
  localparam int STEP_W  = 5;

  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_TILE_SIZE    = 2'd2;

  localparam logic [WREG_W-1:0]  RST_WIDTH  = 12'd640;
  localparam logic [HREG_W-1:0]  RST_HEIGHT = 13'd480;
  localparam logic [TSIZE_W-1:0] RST_TILE   = 7'd8;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

endpackage

>>> design/tap_ram.sv
module tap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/tap_div.sv
module tap_div
  import tap_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [AREA_W-1:0] divisor,
  output logic              busy,
  output logic [PIX_W-1:0]  quot
);

  // Restoring division, one quotient bit per cycle.
  logic [SUM_W-1:0]  acc_r;
  logic [AREA_W-1:0] rem_r;
  logic [AREA_W-1:0] div_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic [AREA_W:0]   trial;
  logic              take;

  assign trial = {rem_r, acc_r[SUM_W-1]};
  assign take  = (trial >= {1'b0, div_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= STEP_W'(SUM_W);
      acc_r  <= dividend;
      rem_r  <= '0;
      div_r  <= divisor;
    end else if (busy_r) begin
      acc_r <= {acc_r[SUM_W-2:0], take};
      rem_r <= take ? AREA_W'(trial - {1'b0, div_r}) : trial[AREA_W-1:0];
      cnt_r <= cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quot = (acc_r > SUM_W'(PIX_MAX)) ? PIX_MAX : acc_r[PIX_W-1:0];

endmodule

>>> design/tile_average_pixelation.sv
// Channel   | Direction | Handshake          | Beat contents
// in        | input     | in_valid/in_stall  | blue, green, red of one raster pixel
// out       | output    | out_valid/out_stall| tile averages, coordinates, size, last mark
// cfg       | input     | cfg_we             | image_width, image_height, tile_size
//
// An accepted pixel reads its tile column's sums from the RAM; then, in S_RMW, it is
// added and the sums are written back through the single read/write port pair.
// A pixel that closes a tile then runs through the bit-serial dividers in S_DIV and,
// when the output register is free, is handed over; otherwise it waits in S_OUT.
// A finished result waits in the output register while the next pixels flow in.
// Reset is synchronous and active low; it restores the default configuration.
// The pixel channel is stalled in any cycle that carries a register write.
// The sums RAM needs no clearing: the first pixel of every tile starts from zero.
`include "tile_average_pixelation_defines.svh"

module tile_average_pixelation
  import tap_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [PIX_W-1:0]    in_blue,
  input  logic [PIX_W-1:0]    in_green,
  input  logic [PIX_W-1:0]    in_red,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [PIX_W-1:0]    out_avg_blue,
  output logic [PIX_W-1:0]    out_avg_green,
  output logic [PIX_W-1:0]    out_avg_red,
  output logic [TCOL_W-1:0]   out_tile_column,
  output logic [TROW_W-1:0]   out_tile_row,
  output logic [TSIZE_W-1:0]  out_tile_width,
  output logic [TSIZE_W-1:0]  out_tile_height,
  output logic                out_last_tile,
  input  logic                cfg_we,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  typedef enum logic [1:0] {S_IDLE, S_RMW, S_DIV, S_OUT} state_t;

  typedef struct packed {
    logic [TCOL_W-1:0]  tc;
    logic [TROW_W-1:0]  tr;
    logic [TSIZE_W-1:0] tw;
    logic [TSIZE_W-1:0] th;
    logic               last;
  } tile_info_t;

  state_t state_r;

  // Configuration registers and their saturated working values.
  logic [WREG_W-1:0]  image_width_r;
  logic [HREG_W-1:0]  image_height_r;
  logic [TSIZE_W-1:0] tile_size_r;
  logic [WREG_W-1:0]  w_eff;
  logic [HREG_W-1:0]  h_eff;
  logic [TSIZE_W-1:0] ts_eff;

  always_comb begin
    if (image_width_r == '0) w_eff = WREG_W'(1);
    else if (image_width_r > WREG_W'(MAX_WIDTH)) w_eff = WREG_W'(MAX_WIDTH);
    else w_eff = image_width_r;
    if (image_height_r == '0) h_eff = HREG_W'(1);
    else if (image_height_r > HREG_W'(MAX_HEIGHT)) h_eff = HREG_W'(MAX_HEIGHT);
    else h_eff = image_height_r;
    if (tile_size_r < TSIZE_W'(2)) ts_eff = TSIZE_W'(2);
    else if (tile_size_r > TSIZE_W'(MAX_TILE)) ts_eff = TSIZE_W'(MAX_TILE);
    else ts_eff = tile_size_r;
  end

  // Raster position; the tile index and tile origin are tracked by counters.
  logic [COL_W-1:0]  pixel_column_r;
  logic [ROW_W-1:0]  pixel_row_r;
  logic [CIT_W-1:0]  column_in_tile_r;
  logic [CIT_W-1:0]  row_in_band_r;
  logic [TCOL_W-1:0] tile_col_r;
  logic [TROW_W-1:0] tile_row_r;
  logic [WREG_W-1:0] col_base_r;
  logic [HREG_W-1:0] row_base_r;

  logic accept;
  logic col_last, row_last, cit_end, rib_end, end_col, end_row;
  logic [WREG_W-1:0] w_left;
  logic [HREG_W-1:0] h_left;
  tile_info_t info_nxt;

  assign in_stall = (state_r != S_IDLE) || cfg_we;
  assign accept   = in_valid && (state_r == S_IDLE) && !cfg_we;

  assign col_last = ({1'b0, pixel_column_r} == w_eff - WREG_W'(1));
  assign row_last = ({1'b0, pixel_row_r} == h_eff - HREG_W'(1));
  assign cit_end  = ({1'b0, column_in_tile_r} == ts_eff - TSIZE_W'(1));
  assign rib_end  = ({1'b0, row_in_band_r} == ts_eff - TSIZE_W'(1));
  assign end_col  = col_last || cit_end;
  assign end_row  = row_last || rib_end;
  assign w_left   = w_eff - col_base_r;
  assign h_left   = h_eff - row_base_r;

  always_comb begin
    info_nxt.tc   = tile_col_r;
    info_nxt.tr   = tile_row_r;
    info_nxt.tw   = (w_left > WREG_W'(ts_eff)) ? ts_eff : w_left[TSIZE_W-1:0];
    info_nxt.th   = (h_left > HREG_W'(ts_eff)) ? ts_eff : h_left[TSIZE_W-1:0];
    info_nxt.last = col_last && row_last;
  end

  // Item held between the read and the write-back.
  logic [PIX_W-1:0] pix_b_r, pix_g_r, pix_r_r;
  logic             first_r;
  logic             emit_r;
  tile_info_t       info_r;

  // Sums RAM: blue, green and red packed side by side per tile column.
  logic                 ram_we;
  logic [3*SUM_W-1:0]   ram_wdata;
  logic [3*SUM_W-1:0]   ram_rdata;
  logic [SUM_W-1:0]     sum_b, sum_g, sum_r;
  logic [AREA_W-1:0]    area;

  always_comb begin
    if (first_r) begin
      sum_b = SUM_W'(pix_b_r);
      sum_g = SUM_W'(pix_g_r);
      sum_r = SUM_W'(pix_r_r);
    end else begin
      sum_b = ram_rdata[3*SUM_W-1:2*SUM_W] + SUM_W'(pix_b_r);
      sum_g = ram_rdata[2*SUM_W-1:SUM_W] + SUM_W'(pix_g_r);
      sum_r = ram_rdata[SUM_W-1:0] + SUM_W'(pix_r_r);
    end
  end

  assign ram_we    = (state_r == S_RMW);
  assign ram_wdata = emit_r ? '0 : {sum_b, sum_g, sum_r};
  assign area      = AREA_W'(info_r.tw) * AREA_W'(info_r.th);

  tap_ram #(.WIDTH(3*SUM_W), .DEPTH(SLOTS)) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (info_r.tc),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (tile_col_r),
    .rdata (ram_rdata)
  );

  // Three dividers run in lockstep, one per channel.
  logic div_start;
  logic busy_b, busy_g, busy_r;
  logic div_busy;
  logic [PIX_W-1:0] q_b, q_g, q_r;

  assign div_start = (state_r == S_RMW) && emit_r;
  assign div_busy  = busy_b || busy_g || busy_r;

  tap_div u_div_b (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_b),
                   .divisor(area), .busy(busy_b), .quot(q_b));
  tap_div u_div_g (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_g),
                   .divisor(area), .busy(busy_g), .quot(q_g));
  tap_div u_div_r (.clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_r),
                   .divisor(area), .busy(busy_r), .quot(q_r));

  // Output register.
  logic             out_valid_r;
  logic [PIX_W-1:0] avg_b_r, avg_g_r, avg_r_r;
  tile_info_t       out_info_r;
  logic             out_load;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      image_width_r    <= RST_WIDTH;
      image_height_r   <= RST_HEIGHT;
      tile_size_r      <= RST_TILE;
      pixel_column_r   <= '0;
      pixel_row_r      <= '0;
      column_in_tile_r <= '0;
      row_in_band_r    <= '0;
      tile_col_r       <= '0;
      tile_row_r       <= '0;
      col_base_r       <= '0;
      row_base_r       <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
        avg_b_r     <= q_b;
        avg_g_r     <= q_g;
        avg_r_r     <= q_r;
        out_info_r  <= info_r;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we && (cfg_index == CFG_IMAGE_WIDTH || cfg_index == CFG_IMAGE_HEIGHT ||
                     cfg_index == CFG_TILE_SIZE)) begin
        // Any register write restarts the frame.
        if (cfg_index == CFG_IMAGE_WIDTH) image_width_r <= cfg_data[WREG_W-1:0];
        if (cfg_index == CFG_IMAGE_HEIGHT) image_height_r <= cfg_data;
        if (cfg_index == CFG_TILE_SIZE) tile_size_r <= cfg_data[TSIZE_W-1:0];
        pixel_column_r   <= '0;
        pixel_row_r      <= '0;
        column_in_tile_r <= '0;
        row_in_band_r    <= '0;
        tile_col_r       <= '0;
        tile_row_r       <= '0;
        col_base_r       <= '0;
        row_base_r       <= '0;
      end else if (accept) begin
        if (col_last) begin
          pixel_column_r   <= '0;
          column_in_tile_r <= '0;
          tile_col_r       <= '0;
          col_base_r       <= '0;
          if (row_last) begin
            pixel_row_r   <= '0;
            row_in_band_r <= '0;
            tile_row_r    <= '0;
            row_base_r    <= '0;
          end else begin
            pixel_row_r <= pixel_row_r + ROW_W'(1);
            if (rib_end) begin
              row_in_band_r <= '0;
              tile_row_r    <= tile_row_r + TROW_W'(1);
              row_base_r    <= row_base_r + HREG_W'(ts_eff);
            end else begin
              row_in_band_r <= row_in_band_r + CIT_W'(1);
            end
          end
        end else begin
          pixel_column_r <= pixel_column_r + COL_W'(1);
          if (cit_end) begin
            column_in_tile_r <= '0;
            tile_col_r       <= tile_col_r + TCOL_W'(1);
            col_base_r       <= col_base_r + WREG_W'(ts_eff);
          end else begin
            column_in_tile_r <= column_in_tile_r + CIT_W'(1);
          end
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pix_b_r <= in_blue;
            pix_g_r <= in_green;
            pix_r_r <= in_red;
            first_r <= (column_in_tile_r == '0) && (row_in_band_r == '0);
            emit_r  <= end_col && end_row;
            info_r  <= info_nxt;
            state_r <= S_RMW;
          end
        end
        S_RMW: begin
          state_r <= emit_r ? S_DIV : S_IDLE;
        end
        S_DIV: begin
          if (!div_busy) state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_avg_blue    = avg_b_r;
  assign out_avg_green   = avg_g_r;
  assign out_avg_red     = avg_r_r;
  assign out_tile_column = out_info_r.tc;
  assign out_tile_row    = out_info_r.tr;
  assign out_tile_width  = out_info_r.tw;
  assign out_tile_height = out_info_r.th;
  assign out_last_tile   = out_info_r.last;

  // A write-back always follows an accepted pixel's read.
  `TAP_ASSERT_NOW(a_rmw_after_accept, state_r == S_RMW, $past(accept))
  // The dividers report busy once they have been started.
  `TAP_ASSERT_NEXT(a_div_started, div_start, div_busy)
  // A new result appears only when a finished tile is handed over.
  `TAP_ASSERT_NOW(a_out_from_tile, $rose(out_valid_r), $past(state_r == S_OUT))

endmodule
